// ===== rtl/bst_pkg.sv =====
// Shared constants, operation codes and cell control types for the breakpoint slot table.
package bst_pkg;

    // Fixed field widths
    localparam int FUNC_W = 2;
    localparam int ADDR_W = 32;
    localparam int NUM_W  = 5;

    // Defaults for the top level parameter and derived widths
    localparam int SLOT_COUNT_DEF = 32;
    localparam int SLOT_W_DEF     = 5;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_CHECK  = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    // Control of one entry cell
    typedef struct packed {
        logic load;   // take the newly inserted slot and address
        logic shift;  // advance one position toward the head cell
        logic wrap;   // this cell closes the ring: take the head cell's entry
    } t_entry_ctl;

    // Control of one free stack cell
    typedef struct packed {
        logic push;   // take the entry of the cell above
        logic pop;    // take the entry of the cell below
    } t_free_ctl;

endpackage

// ===== rtl/bst_intf.sv =====
// Request and response channel interfaces of the breakpoint slot table.
interface bst_req_if;
    logic                       valid;
    logic                       ready;
    logic [bst_pkg::FUNC_W-1:0] func;
    logic [bst_pkg::ADDR_W-1:0] address;
    logic [bst_pkg::NUM_W-1:0]  number;

    modport source (output valid, output func, output address, output number, input ready);
    modport sink   (input valid, input func, input address, input number, output ready);
endinterface

interface bst_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic [bst_pkg::NUM_W-1:0]  slot_number;
    logic [bst_pkg::ADDR_W-1:0] hit_address;

    modport source (output valid, output ok, output slot_number, output hit_address,
                    input ready);
    modport sink   (input valid, input ok, input slot_number, input hit_address,
                    output ready);
endinterface

// ===== rtl/bst_entry_cell.sv =====
// One cell of the active list chain: holds a slot number and its breakpoint address.
module bst_entry_cell #(
    parameter int SLOT_W = bst_pkg::SLOT_W_DEF
) (
    input  logic                       i_clk,
    input  bst_pkg::t_entry_ctl        i_ctl,
    input  logic [SLOT_W-1:0]          i_next_slot,
    input  logic [bst_pkg::ADDR_W-1:0] i_next_addr,
    input  logic [SLOT_W-1:0]          i_head_slot,
    input  logic [bst_pkg::ADDR_W-1:0] i_head_addr,
    input  logic [SLOT_W-1:0]          i_new_slot,
    input  logic [bst_pkg::ADDR_W-1:0] i_new_addr,
    output logic [SLOT_W-1:0]          o_slot,
    output logic [bst_pkg::ADDR_W-1:0] o_addr
);
    import bst_pkg::*;

    logic [SLOT_W-1:0] r_slot;
    logic [ADDR_W-1:0] r_addr;

    // Load a new entry, or advance along the ring
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_slot <= i_new_slot;
            r_addr <= i_new_addr;
        end else if (i_ctl.shift) begin
            if (i_ctl.wrap) begin
                r_slot <= i_head_slot;
                r_addr <= i_head_addr;
            end else begin
                r_slot <= i_next_slot;
                r_addr <= i_next_addr;
            end
        end
    end

    assign o_slot = r_slot;
    assign o_addr = r_addr;

endmodule

// ===== rtl/bst_free_cell.sv =====
// One cell of the free slot stack chain; the cell at the top holds the next slot to hand out.
module bst_free_cell #(
    parameter int SLOT_W     = bst_pkg::SLOT_W_DEF,
    parameter int RESET_SLOT = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bst_pkg::t_free_ctl i_ctl,
    input  logic [SLOT_W-1:0]  i_prev_slot,
    input  logic [SLOT_W-1:0]  i_next_slot,
    output logic [SLOT_W-1:0]  o_slot
);
    import bst_pkg::*;

    logic [SLOT_W-1:0] r_slot;

    // Start in slot order; push moves entries down, pop moves them up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= SLOT_W'(RESET_SLOT);
        end else if (i_ctl.push) begin
            r_slot <= i_prev_slot;
        end else if (i_ctl.pop) begin
            r_slot <= i_next_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

// ===== rtl/breakpoint_slot_table.sv =====
// Breakpoint slot table: SLOT_COUNT numbered slots, handed out from a free stack (0, 1, 2, ...
// after reset, freed slots reused last-freed first), kept in an active chain in allocation
// order. Insert goes through S_DONE from acceptance until the next request can be taken. Delete and
// check step through S_WALK once per active slot, then go through S_DONE: the
// active chain rotates one position per cycle past the comparator on its head cell, and a full
// turn restores the order, a deleted entry being dropped out of the ring as it passes. A
// finished response sits in an output register, so a new request is taken while it waits.
module breakpoint_slot_table #(
    parameter int SLOT_COUNT = bst_pkg::SLOT_COUNT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bst_req_if.sink      i_req,
    bst_rsp_if.source    o_rsp
);
    import bst_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W  = (SLOT_W > NUM_W) ? SLOT_W : NUM_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_left, n_left;
    logic [FUNC_W-1:0]  r_func, n_func;
    logic [ADDR_W-1:0]  r_pc, n_pc;
    logic [NUM_W-1:0]   r_num, n_num;
    logic               r_hit, n_hit;
    logic [NUM_W-1:0]   r_hslot, n_hslot;
    logic [ADDR_W-1:0]  r_haddr, n_haddr;
    logic               r_out_valid, n_out_valid;
    logic               r_out_ok;
    logic [NUM_W-1:0]   r_out_slot;
    logic [ADDR_W-1:0]  r_out_addr;

    logic [SLOT_W-1:0]  w_eslot [SLOT_COUNT];
    logic [ADDR_W-1:0]  w_eaddr [SLOT_COUNT];
    logic [SLOT_W-1:0]  w_fslot [SLOT_COUNT];

    logic               w_accept;
    logic               w_full;
    logic               w_ins_go;
    logic               w_walk;
    logic               w_drop;
    logic               w_match;
    logic               w_out_load;
    logic [CNT_W-1:0]   w_last_idx;

    // Request side
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CNT_W'(SLOT_COUNT));
    assign w_ins_go    = w_accept && (i_req.func == FN_INSERT) && !w_full;
    assign w_walk      = (r_state == S_WALK);
    assign w_last_idx  = r_count - CNT_W'(1);

    // Head cell comparators
    assign w_drop  = w_walk && (r_func == FN_DELETE) && !r_hit &&
                     (CMP_W'(w_eslot[0]) == CMP_W'(r_num));
    assign w_match = w_walk && (r_func == FN_CHECK) && !r_hit && (w_eaddr[0] == r_pc);

    // Active chain
    for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_entry
        t_entry_ctl        w_ctl;
        logic [SLOT_W-1:0] w_next_slot;
        logic [ADDR_W-1:0] w_next_addr;

        assign w_ctl.load  = w_ins_go && (CNT_W'(i) == r_count);
        assign w_ctl.shift = w_walk;
        assign w_ctl.wrap  = (CNT_W'(i) == w_last_idx) && !w_drop;

        if (i == SLOT_COUNT - 1) begin : g_last
            assign w_next_slot = w_eslot[i];
            assign w_next_addr = w_eaddr[i];
        end else begin : g_mid
            assign w_next_slot = w_eslot[i+1];
            assign w_next_addr = w_eaddr[i+1];
        end

        bst_entry_cell #(
            .SLOT_W (SLOT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_next_slot (w_next_slot),
            .i_next_addr (w_next_addr),
            .i_head_slot (w_eslot[0]),
            .i_head_addr (w_eaddr[0]),
            .i_new_slot  (w_fslot[0]),
            .i_new_addr  (i_req.address),
            .o_slot      (w_eslot[i]),
            .o_addr      (w_eaddr[i])
        );
    end

    // Free slot stack
    for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_free
        t_free_ctl         w_ctl;
        logic [SLOT_W-1:0] w_prev_slot;
        logic [SLOT_W-1:0] w_next_slot;

        assign w_ctl.push = w_drop;
        assign w_ctl.pop  = w_ins_go;

        if (i == 0) begin : g_top
            assign w_prev_slot = w_eslot[0];
        end else begin : g_below
            assign w_prev_slot = w_fslot[i-1];
        end

        if (i == SLOT_COUNT - 1) begin : g_bottom
            assign w_next_slot = w_fslot[i];
        end else begin : g_above
            assign w_next_slot = w_fslot[i+1];
        end

        bst_free_cell #(
            .SLOT_W     (SLOT_W),
            .RESET_SLOT (i)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_prev_slot (w_prev_slot),
            .i_next_slot (w_next_slot),
            .o_slot      (w_fslot[i])
        );
    end

    // Sequencer
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_left  = r_left;
        n_func  = r_func;
        n_pc    = r_pc;
        n_num   = r_num;
        n_hit   = r_hit;
        n_hslot = r_hslot;
        n_haddr = r_haddr;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_func  = i_req.func;
                    n_pc    = i_req.address;
                    n_num   = i_req.number;
                    n_left  = r_count;
                    n_hit   = 1'b0;
                    n_hslot = '0;
                    n_haddr = '0;
                    priority if (i_req.func == FN_INSERT) begin
                        if (!w_full) begin
                            n_hit   = 1'b1;
                            n_hslot = NUM_W'(w_fslot[0]);
                            n_count = r_count + CNT_W'(1);
                        end
                        n_state = S_DONE;
                    end else if ((i_req.func == FN_DELETE || i_req.func == FN_CHECK) &&
                                 (r_count != '0)) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_WALK: begin
                // Drop a deleted entry out of the ring, record the first address hit
                if (w_drop) begin
                    n_hit   = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end
                if (w_match) begin
                    n_hit   = 1'b1;
                    n_hslot = NUM_W'(w_eslot[0]);
                    n_haddr = w_eaddr[0];
                end
                n_left = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: load a finished transaction, drop it once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_func  <= n_func;
        r_pc    <= n_pc;
        r_num   <= n_num;
        r_hit   <= n_hit;
        r_hslot <= n_hslot;
        r_haddr <= n_haddr;
        if (w_out_load) begin
            r_out_ok   <= r_hit;
            r_out_slot <= r_hslot;
            r_out_addr <= r_haddr;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ok          = r_out_ok;
    assign o_rsp.slot_number = r_out_slot;
    assign o_rsp.hit_address = r_out_addr;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOT_COUNT))
        else $error("active count beyond slot count");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_go |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the active chain");

    a_walk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_walk |-> (r_left != '0) && (r_left <= r_count + CNT_W'(r_hit)))
        else $error("walk step counter out of range");

    a_drop_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drop |=> !w_drop)
        else $error("two entries dropped in one delete");
`endif

endmodule

// ===== sim/breakpoint_slot_table_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the breakpoint slot table: random and directed slot operations.
module breakpoint_slot_table_test;
    import bst_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;

    typedef struct packed {
        t_func              func;
        logic [ADDR_W-1:0]  address;
        logic [NUM_W-1:0]   number;
    } t_bp_request;

    typedef struct packed {
        logic               ok;
        logic [NUM_W-1:0]   slot_number;
        logic [ADDR_W-1:0]  hit_address;
    } t_bp_reply;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bst_req_if req_ch();
    bst_rsp_if rsp_ch();

    breakpoint_slot_table #(.SLOT_COUNT(SLOTS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #2 i_clk = ~i_clk;

    // Shadow slot pool: free stack (last freed on top) and active slots in allocation order
    logic [NUM_W-1:0]  free_stack[$];
    logic [NUM_W-1:0]  active_order[$];
    logic [ADDR_W-1:0] slot_address[SLOTS];
    logic              slot_active[SLOTS];

    t_bp_request queued_requests[$];
    t_bp_reply   due_replies[$];
    logic [ADDR_W-1:0] inserted_addresses[$];
    int bad_replies    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Apply one operation to the shadow pool and return the reply it should give
    function automatic t_bp_reply apply_slot_op(t_bp_request r);
        t_bp_reply res;
        int k;
        res = '0;
        case (r.func)
            FN_INSERT: begin
                if (free_stack.size() > 0) begin
                    res.ok          = 1'b1;
                    res.slot_number = free_stack.pop_front();
                    slot_active[res.slot_number]  = 1'b1;
                    slot_address[res.slot_number] = r.address;
                    active_order.push_back(res.slot_number);
                end
            end
            FN_DELETE: begin
                if (slot_active[r.number]) begin
                    for (k = 0; k < active_order.size(); k++) begin
                        if (active_order[k] == r.number) break;
                    end
                    active_order.delete(k);
                    slot_active[r.number]  = 1'b0;
                    slot_address[r.number] = '0;
                    free_stack.push_front(r.number);
                    res.ok = 1'b1;
                end
            end
            FN_CHECK: begin
                // first hit in allocation order wins
                for (k = 0; k < active_order.size(); k++) begin
                    if (slot_address[active_order[k]] == r.address) begin
                        res.ok          = 1'b1;
                        res.slot_number = active_order[k];
                        res.hit_address = r.address;
                        break;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void flag_reply(string what, t_bp_reply want, t_bp_reply got);
        bad_replies++;
        if (bad_replies <= 10) begin
            $display("%0t: %s: expected ok=%0b slot=%0d addr=%h, got ok=%0b slot=%0d addr=%h",
                     $realtime, what, want.ok, want.slot_number, want.hit_address,
                     got.ok, got.slot_number, got.hit_address);
        end
    endfunction

    task automatic add_op(t_func f, logic [ADDR_W-1:0] a, logic [NUM_W-1:0] n);
        queued_requests.push_back('{f, a, n});
    endtask

    // Draw an address: extremes, repeats of inserted ones, or fully random
    function automatic logic [ADDR_W-1:0] pick_address();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        if (sel < 5 && inserted_addresses.size() > 0)
            return inserted_addresses[$urandom_range(inserted_addresses.size() - 1)];
        return $urandom;
    endfunction

    task automatic add_random_op(int insert_pct, int delete_pct);
        int roll;
        logic [ADDR_W-1:0] a;
        roll = $urandom_range(99);
        a    = pick_address();
        if (roll < insert_pct) begin
            add_op(FN_INSERT, a, NUM_W'($urandom));
            inserted_addresses.push_back(a);
            if (inserted_addresses.size() > 64) void'(inserted_addresses.pop_front());
        end else if (roll < insert_pct + delete_pct) begin
            add_op(FN_DELETE, $urandom, NUM_W'($urandom_range(SLOTS - 1)));
        end else if (roll < 97) begin
            add_op(FN_CHECK, a, NUM_W'($urandom));
        end else begin
            add_op(FN_NONE, $urandom, NUM_W'($urandom));
        end
    endtask

    // Hold until every queued transaction is sent and every reply has come back
    task automatic wait_for_drain();
        while (queued_requests.size() > 0 || req_ch.valid || due_replies.size() > 0)
            @(posedge i_clk);
    endtask

    // Drive requests from the queue; predict at each accepted transaction
    always @(posedge i_clk) begin
        t_bp_request nxt;
        t_bp_request taken;
        if (!i_rst_n) begin
            req_ch.valid   <= 1'b0;
            req_ch.func    <= FN_NONE;
            req_ch.address <= '0;
            req_ch.number  <= '0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                taken.func    = t_func'(req_ch.func);
                taken.address = req_ch.address;
                taken.number  = req_ch.number;
                due_replies.push_back(apply_slot_op(taken));
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (queued_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = queued_requests.pop_front();
                    req_ch.valid   <= 1'b1;
                    req_ch.func    <= nxt.func;
                    req_ch.address <= nxt.address;
                    req_ch.number  <= nxt.number;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Compare each accepted reply with the oldest prediction; stall at random
    always @(posedge i_clk) begin
        t_bp_reply got;
        t_bp_reply want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.ok          = rsp_ch.ok;
                got.slot_number = rsp_ch.slot_number;
                got.hit_address = rsp_ch.hit_address;
                if (due_replies.size() == 0) begin
                    flag_reply("reply with nothing outstanding", '0, got);
                end else begin
                    want = due_replies.pop_front();
                    if (got.ok !== want.ok || got.slot_number !== want.slot_number ||
                        got.hit_address !== want.hit_address) begin
                        flag_reply("reply mismatch", want, got);
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Timeout
    initial begin
        #2_000_000;
        $display("FAIL breakpoint_slot_table");
        $finish;
    end

    initial begin
        int idle_by_phase[4];
        int stall_by_phase[4];
        logic [NUM_W-1:0] release_order[$];
        int p;
        int i;
        int pick;

        idle_by_phase  = '{0, 66, 0, 32};
        stall_by_phase = '{0, 0, 66, 32};

        // Reset state of the shadow pool
        for (i = 0; i < SLOTS; i++) begin
            free_stack.push_back(NUM_W'(i));
            slot_address[i] = '0;
            slot_active[i]  = 1'b0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty check, extremes, duplicates, head/middle/tail delete, reuse order
        add_op(FN_CHECK,  32'h0000_0000, 5'd0);
        add_op(FN_INSERT, 32'h0000_0000, 5'd0);
        add_op(FN_INSERT, 32'hFFFF_FFFF, 5'd31);
        add_op(FN_INSERT, 32'h1234_5678, 5'd0);
        add_op(FN_INSERT, 32'h0000_0000, 5'd0);
        add_op(FN_CHECK,  32'h0000_0000, 5'd0);
        add_op(FN_CHECK,  32'hFFFF_FFFF, 5'd0);
        add_op(FN_CHECK,  32'hDEAD_BEEF, 5'd0);
        add_op(FN_DELETE, 32'h0000_0000, 5'd0);
        add_op(FN_CHECK,  32'h0000_0000, 5'd0);
        add_op(FN_DELETE, 32'h0000_0000, 5'd0);
        add_op(FN_DELETE, 32'h0000_0000, 5'd31);
        add_op(FN_DELETE, 32'h0000_0000, 5'd2);
        add_op(FN_DELETE, 32'h0000_0000, 5'd3);
        add_op(FN_INSERT, 32'hA5A5_A5A5, 5'd0);
        add_op(FN_INSERT, 32'h5A5A_5A5A, 5'd0);
        add_op(FN_CHECK,  32'h5A5A_5A5A, 5'd0);
        add_op(FN_NONE,   32'hFFFF_FFFF, 5'd31);
        add_op(FN_DELETE, 32'h0000_0000, 5'd1);
        add_op(FN_DELETE, 32'h0000_0000, 5'd3);
        add_op(FN_DELETE, 32'h0000_0000, 5'd2);
        add_op(FN_CHECK,  32'hFFFF_FFFF, 5'd0);
        add_op(FN_INSERT, 32'h0000_0001, 5'd0);
        wait_for_drain();

        for (p = 0; p < 4; p++) begin
            send_idle_pct  = idle_by_phase[p];
            recv_stall_pct = stall_by_phase[p];

            if (p == 0) begin
                // Fill past full, probe, then release every slot in random order
                for (i = 0; i < SLOTS + 2; i++) begin
                    add_op(FN_INSERT, $urandom, NUM_W'($urandom));
                    inserted_addresses.push_back(queued_requests[$].address);
                end
                for (i = 0; i < 8; i++) add_op(FN_CHECK, pick_address(), NUM_W'($urandom));
                for (i = 0; i < SLOTS; i++) release_order.push_back(NUM_W'(i));
                for (i = 0; i < SLOTS; i++) begin
                    pick = $urandom_range(release_order.size() - 1);
                    add_op(FN_DELETE, $urandom, release_order[pick]);
                    release_order.delete(pick);
                    if (i % 4 == 3) add_op(FN_CHECK, pick_address(), NUM_W'($urandom));
                end
            end

            // Grow the pool, then shrink it
            for (i = 0; i < 50; i++) add_random_op(70, 15);
            for (i = 0; i < 35; i++) add_random_op(15, 70);

            // Pause the sender until every reply of this phase has come
            wait_for_drain();
        end

        repeat (40) @(posedge i_clk);
        if (bad_replies == 0 && due_replies.size() == 0) begin
            $display("PASS breakpoint_slot_table");
        end else begin
            $display("FAIL breakpoint_slot_table");
        end
        $finish;
    end

endmodule
